FILE: rtl/core/alids_pkg.sv
// ----------------------------------------------------------------------------
// alids_pkg
// Shared types and codes for the ordered list block and its storage cells.
// ----------------------------------------------------------------------------
package alids_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

   // what a cell does with its entry this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT
   } alids_cell_cmd_type;

   typedef struct packed {
      logic               cmp_en;  // latch a compare against the new item
      logic               live;    // cell lies below the live count
      alids_cell_cmd_type cmd;
   } alids_cell_ctrl_type;

endpackage

FILE: rtl/core/alids_cell.sv
// ----------------------------------------------------------------------------
// alids_cell
// One list entry: holds a value, compares it, and trades it with neighbors.
// ----------------------------------------------------------------------------
module alids_cell (
   input  logic                                 clock,
   input  alids_pkg::alids_cell_ctrl_type       ctrl,
   input  logic [alids_pkg::VALUE_W-1:0]        cmp_value,
   input  logic [alids_pkg::VALUE_W-1:0]        load_value,
   input  logic [alids_pkg::VALUE_W-1:0]        left_entry,
   input  logic [alids_pkg::VALUE_W-1:0]        right_entry,
   output logic [alids_pkg::VALUE_W-1:0]        entry,
   output logic                                 match
);

   logic [alids_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                          match_ff, match_in;

   always_comb begin
      case (ctrl.cmd)
         alids_pkg::CELL_HOLD:       entry_in = entry_ff;
         alids_pkg::CELL_LOAD:       entry_in = load_value;
         alids_pkg::CELL_TAKE_LEFT:  entry_in = left_entry;
         alids_pkg::CELL_TAKE_RIGHT: entry_in = right_entry;
         default:                    entry_in = entry_ff;
      endcase
   end

   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = ctrl.live && (entry_ff == cmp_value);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

FILE: rtl/core/array_list_insert_delete_search_top.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_search_top
// Ordered list of signed 32-bit entries with insert, delete and search.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata (low bit up)            | tuser
//   --------+-----+-------------------------------+-------------
//   req_    | in  | value[31:0], position[38:32]  | func[1:0]
//   rsp_    | out | index[5:0], count[12:6]       | status[1:0]
//
// An item goes through the accept cycle, in which every cell compares
// its entry with the item's value in parallel, and a resolve cycle, in which
// the first match is picked from the registered match row and all cells
// shift or load at once. One item is in work at a time.
// The resolve cycle waits while the result register is full and not taken;
// the result register lets a new item in while the last result waits.
// Reset clears the live count and the handshake state; entry storage is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search_top #(
   parameter int DEPTH = alids_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[38:32], zero pad
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // index[5:0], count[12:6], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int CmpW = ((CntW > alids_pkg::POS_W) ? CntW : alids_pkg::POS_W) + 1;

   // input item fields
   logic [alids_pkg::VALUE_W-1:0] req_value;
   logic [alids_pkg::POS_W-1:0]   req_position;
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[38:32];

   logic accept;
   logic busy_ff, busy_in;
   logic [CntW-1:0] count_ff, count_in;

   // held item
   logic [alids_pkg::FUNC_W-1:0]  func_ff;
   logic [alids_pkg::VALUE_W-1:0] value_ff;
   logic [alids_pkg::POS_W-1:0]   pos_ff;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [alids_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [alids_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [alids_pkg::COUNT_W-1:0]  rsp_count_ff;

   // cell row
   alids_pkg::alids_cell_ctrl_type cell_ctrl [DEPTH];
   logic [alids_pkg::VALUE_W-1:0]  cell_entry [DEPTH];
   logic [DEPTH-1:0]               match_row;

   // resolve logic
   logic                           finish;
   logic                           found;
   logic [DEPTH-1:0]               below_first;
   logic [DEPTH-1:0]               first_hit;
   logic [DEPTH-1:0]               at_or_above;
   logic [IdxW-1:0]                hit_idx;
   logic [CmpW-1:0]                pos_ext;
   logic [CmpW-1:0]                cnt_ext;
   logic                           full;
   logic                           do_ins;
   logic                           do_del;
   logic [alids_pkg::STATUS_W-1:0] status;
   logic [IdxW-1:0]                res_idx;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign finish     = busy_ff && (!rsp_valid_ff || rsp_tready);

   // isolate the first live match and everything at or after it
   assign below_first = (match_row - DEPTH'(1)) & ~match_row;
   assign found       = |match_row;
   assign first_hit   = match_row & ~(match_row - DEPTH'(1));
   assign at_or_above = found ? ~below_first : '0;

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_hit[i]) begin
            hit_idx = hit_idx | IdxW'(i);
         end
      end
   end

   assign pos_ext = CmpW'(pos_ff);
   assign cnt_ext = CmpW'(count_ff);
   assign full    = count_ff >= CntW'(DEPTH);

   always_comb begin
      status  = alids_pkg::ST_OK;
      res_idx = '0;
      do_ins  = 1'b0;
      do_del  = 1'b0;
      case (func_ff)
         alids_pkg::FUNC_INSERT: begin
            if (full) begin
               status = alids_pkg::ST_FULL;
            end else if (pos_ext == '0 || pos_ext > cnt_ext + CmpW'(1)) begin
               status = alids_pkg::ST_BAD_POS;
            end else begin
               do_ins = 1'b1;
            end
         end
         alids_pkg::FUNC_DELETE: begin
            if (!found) begin
               status = alids_pkg::ST_NOT_FOUND;
            end else begin
               do_del  = 1'b1;
               res_idx = hit_idx;
            end
         end
         alids_pkg::FUNC_SEARCH: begin
            if (!found) begin
               status = alids_pkg::ST_NOT_FOUND;
            end else begin
               res_idx = hit_idx;
            end
         end
         default: begin
            status = alids_pkg::ST_OK;
         end
      endcase
   end

   // per-cell control: insert shifts the tail up, delete pulls it down
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctrl[i].cmp_en = accept;
         cell_ctrl[i].live   = CntW'(i) < count_ff;
         cell_ctrl[i].cmd    = alids_pkg::CELL_HOLD;
         if (finish && do_ins) begin
            if (CmpW'(i) + CmpW'(1) == pos_ext) begin
               cell_ctrl[i].cmd = alids_pkg::CELL_LOAD;
            end else if (CmpW'(i) + CmpW'(1) > pos_ext) begin
               cell_ctrl[i].cmd = alids_pkg::CELL_TAKE_LEFT;
            end
         end else if (finish && do_del && at_or_above[i]) begin
            cell_ctrl[i].cmd = alids_pkg::CELL_TAKE_RIGHT;
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [alids_pkg::VALUE_W-1:0] left_w;
      logic [alids_pkg::VALUE_W-1:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = cell_entry[g];
      end else begin : g_mid_l
         assign left_w = cell_entry[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = cell_entry[g];
      end else begin : g_mid_r
         assign right_w = cell_entry[g+1];
      end
      alids_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[g]),
         .cmp_value   (req_value),
         .load_value  (value_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (cell_entry[g]),
         .match       (match_row[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (finish && do_ins) begin
         count_in = count_ff + CntW'(1);
      end else if (finish && do_del) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold the item, load the result
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_tuser;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (finish) begin
         rsp_status_ff <= status;
         rsp_index_ff  <= alids_pkg::INDEX_W'(res_idx);
         rsp_count_ff  <= alids_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_index_ff};

`ifndef SYNTH
   // a match can only come from a live cell
   a_match_live : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((match_row >> count_ff) == '0))
      else $error("match flagged beyond live count");

   // a successful insert grows the list by one
   a_ins_count : assert property (@(posedge clock) disable iff (reset)
      (finish && do_ins) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("insert did not grow count");

   // a successful delete shrinks the list by one
   a_del_count : assert property (@(posedge clock) disable iff (reset)
      (finish && do_del) |=> (count_ff == $past(count_ff) - CntW'(1)))
      else $error("delete did not shrink count");

   // the live count never passes the depth
   a_count_max : assert property (@(posedge clock) disable iff (reset)
      accept |-> (count_ff <= CntW'(DEPTH)))
      else $error("live count beyond depth");
`endif

endmodule

FILE: tb/tb_array_list_insert_delete_search_top.sv
// ----------------------------------------------------------------------------
// tb_array_list_insert_delete_search_top
// Self-checking bench for the ordered list block: insert, delete and search.
// A shadow list updates on every accepted request item and predicts the
// status, index and count of each response. Directed corner cases come
// first. Random traffic follows, swinging the list between full and empty,
// with random idle cycles on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_array_list_insert_delete_search_top;
   timeunit 1ns;
   timeprecision 1ps;

   import alids_pkg::*;

   localparam int                LIST_DEPTH  = DEPTH_DEFAULT;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;  // no operation, must be ignored
   localparam int                IDLE_PCT    = 36;
   localparam int                RANDOM_OPS  = 650;
   localparam int                HOLD_CYCLES = 64;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [COUNT_W-1:0]  count;
   } list_reply_t;

   // Shadow copy of the list; turns accepted operations into expected replies.
   class list_shadow;
      logic signed [VALUE_W-1:0] entries [LIST_DEPTH];
      int                        live;
      list_reply_t               due_replies [$];
      int                        faults;

      function new();
         live   = 0;
         faults = 0;
      endfunction

      function int first_hit(logic signed [VALUE_W-1:0] value);
         for (int i = 0; i < live; i++) begin
            if (entries[i] == value) return i;
         end
         return -1;
      endfunction

      function void accept_op(logic [FUNC_W-1:0] func, logic signed [VALUE_W-1:0] value,
                              logic [POS_W-1:0] pos);
         list_reply_t r;
         int          hit;
         r.status = ST_OK;
         r.index  = '0;
         case (func)
            FUNC_INSERT: begin
               if (live >= LIST_DEPTH) begin
                  r.status = ST_FULL;
               end else if (int'(pos) < 1 || int'(pos) > live + 1) begin
                  r.status = ST_BAD_POS;
               end else begin
                  for (int i = live; i > int'(pos) - 1; i--) entries[i] = entries[i - 1];
                  entries[int'(pos) - 1] = value;
                  live++;
               end
            end
            FUNC_DELETE: begin
               hit = first_hit(value);
               if (hit < 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  for (int i = hit; i + 1 < live; i++) entries[i] = entries[i + 1];
                  live--;
                  r.index = INDEX_W'(hit);
               end
            end
            FUNC_SEARCH: begin
               hit = first_hit(value);
               if (hit < 0) r.status = ST_NOT_FOUND;
               else r.index = INDEX_W'(hit);
            end
            default: ;
         endcase
         r.count = COUNT_W'(live);
         due_replies.push_back(r);
      endfunction

      function void compare_reply(list_reply_t got);
         list_reply_t want;
         if (due_replies.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: response with nothing outstanding: status %0d index %0d count %0d",
                        $realtime, got.status, got.index, got.count);
            return;
         end
         want = due_replies.pop_front();
         if (got !== want) begin
            faults++;
            if (faults <= 10)
               $display("%0t: mismatch: status %0d/%0d index %0d/%0d count %0d/%0d (exp/got)",
                        $realtime, want.status, got.status, want.index, got.index,
                        want.count, got.count);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;     // value[31:0], position[38:32], zero pad
   logic [1:0]  req_tuser  = '0;     // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // index[5:0], count[12:6], zero pad
   logic [1:0]  rsp_tuser;           // status[1:0]

   list_shadow book = new();
   bit         idle_on      = 1'b1;  // random idle cycles on both channels
   bit         hold_request = 1'b0;  // ask the response side for one long hold-off

   array_list_insert_delete_search_top #(.DEPTH(LIST_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Offer one request item and hold it until the block takes it. Random idle
   // cycles go in front; back-to-back items keep tvalid high without a dip.
   task automatic offer(input logic [FUNC_W-1:0] func, input logic signed [VALUE_W-1:0] value,
                        input logic [POS_W-1:0] pos);
      if (idle_on) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, pos, value};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      book.accept_op(func, value, pos);
   endtask

   // Pick a value: mostly one already in the list or from a narrow pool so that
   // hits and duplicates are common, sometimes any 32-bit pattern.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int k;
      k = $urandom_range(0, 9);
      if (k < 5 && book.live > 0) return book.entries[$urandom_range(0, book.live - 1)];
      if (k < 8) return $signed($urandom_range(0, 15)) - 8;
      return $urandom;
   endfunction

   // Response side: check every accepted item, then decide tready for the next
   // edge. One long hold-off lets the block fill up and stall its input.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            book.compare_reply({rsp_tuser, rsp_tdata[5:0], rsp_tdata[12:6]});
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on) begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus.
   initial begin
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  pos;
      int                phase;
      int                r;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty list: misses, bad positions and the unused code.
      offer(FUNC_SEARCH, 32'sd5, 7'd1);
      offer(FUNC_DELETE, 32'sd5, 7'd1);
      offer(FUNC_INSERT, 32'sd9, 7'd0);
      offer(FUNC_INSERT, 32'sd9, 7'd2);
      offer(FUNC_INSERT, 32'sd9, 7'd127);
      offer(FUNC_UNUSED, 32'sd9, 7'd1);
      // Build [7, min, 7, max]: front, end and middle inserts, a duplicate.
      offer(FUNC_INSERT, 32'sh8000_0000, 7'd1);
      offer(FUNC_INSERT, 32'sh7fff_ffff, 7'd2);
      offer(FUNC_INSERT, 32'sd7, 7'd2);
      offer(FUNC_INSERT, 32'sd7, 7'd1);
      offer(FUNC_SEARCH, 32'sd7, 7'd0);
      offer(FUNC_SEARCH, 32'sh7fff_ffff, 7'd127);
      offer(FUNC_SEARCH, 32'sh8000_0000, 7'd1);
      // Delete must drop only the first match and close the gap.
      offer(FUNC_DELETE, 32'sd7, 7'd1);
      offer(FUNC_SEARCH, 32'sd7, 7'd1);
      offer(FUNC_DELETE, 32'sh7fff_ffff, 7'd1);
      offer(FUNC_INSERT, 32'sd1, 7'd4);
      offer(FUNC_INSERT, 32'sd0, 7'd3);
      offer(FUNC_UNUSED, -32'sd1, 7'd127);
      offer(FUNC_SEARCH, -32'sd1, 7'd1);
      offer(FUNC_DELETE, 32'sh8000_0000, 7'd1);

      // Random traffic in phases: grow to full, mixed, shrink to empty, mixed.
      for (int n = 0; n < RANDOM_OPS; n++) begin
         idle_on = !(n >= 250 && n < 350);  // one stretch at full rate
         if (n == 40) hold_request = 1'b1;
         phase = (n / 160) % 4;
         r     = $urandom_range(0, 99);
         if (r >= 98) begin
            func = FUNC_UNUSED;
         end else if (phase == 0) begin
            func = (r < 80) ? FUNC_INSERT : (r < 90) ? FUNC_DELETE : FUNC_SEARCH;
         end else if (phase == 2) begin
            func = (r < 15) ? FUNC_INSERT : (r < 85) ? FUNC_DELETE : FUNC_SEARCH;
         end else begin
            func = (r < 40) ? FUNC_INSERT : (r < 70) ? FUNC_DELETE : FUNC_SEARCH;
         end
         // Mostly legal positions; the rest spans the whole field.
         if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(1, book.live + 1));
         else pos = POS_W'($urandom_range(0, 127));
         offer(func, pick_value(), pos);
      end
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any stray response.
      while (book.due_replies.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (book.faults == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: array_list_insert_delete_search_top.f
rtl/core/alids_pkg.sv
rtl/core/alids_cell.sv
rtl/core/array_list_insert_delete_search_top.sv
tb/tb_array_list_insert_delete_search_top.sv
